@@ rtl/core/tcpts_pkg.sv @@
// shared constants, status codes and result type for the tcp timestamp option parser
package tcpts_pkg;

    localparam logic [7:0] KIND_END      = 8'h00;
    localparam logic [7:0] KIND_NOP      = 8'h01;
    localparam logic [7:0] KIND_TS       = 8'h08;
    localparam logic [7:0] LEN_TS        = 8'd10;
    localparam logic [7:0] LEN_MIN       = 8'd2;
    localparam logic [7:0] TS_BODY_BYTES = 8'd8;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_EOL   = 2'd1,
        ST_BAD   = 2'd2,
        ST_NONE  = 2'd3
    } status_t;

    typedef struct packed {
        status_t     status;
        logic [31:0] ts_value;
        logic [31:0] ts_reply;
    } result_t;

endpackage

@@ rtl/core/tcpts_if.sv @@
// valid/ready channel interfaces for option bytes and parse results
interface tcpts_opt_if;
    logic       valid;
    logic       ready;
    logic [7:0] opt_byte;
    logic       last_byte;

    modport source (output valid, output opt_byte, output last_byte, input ready);
    modport sink (input valid, input opt_byte, input last_byte, output ready);
endinterface

interface tcpts_res_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] ts_value;
    logic [31:0] ts_reply;

    modport source (output valid, output status, output ts_value, output ts_reply,
                    input ready);
    modport sink (input valid, input status, input ts_value, input ts_reply,
                  output ready);
endinterface

@@ rtl/core/tcpts_top.sv @@
// Walks a TCP options area given one byte per transfer, with last_byte set on the
// final byte, and returns one result per area: status plus the timestamp value and
// echo reply of the first kind-8, length-10 option. A byte is taken every cycle
// unless a last byte waits on a result not yet taken; the last byte is held in the
// input register, then its result in the result register, which lets the next
// area's bytes keep flowing while a result waits; only a last byte stalls behind
// a result that has not been taken. Non-last bytes produce no output transfer.
module tcp_timestamp_option_parser_top
    import tcpts_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    tcpts_opt_if.sink   opt,
    tcpts_res_if.source res
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    step_res;
    logic       out_free;
    logic       step_go;

    assign out_free  = !out_valid_reg || res.ready;
    assign step_go   = in_valid_reg && (!in_last_reg || out_free);
    assign opt.ready = !in_valid_reg || step_go;

    tcpts_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (step_go),
        .opt_byte  (in_byte_reg),
        .last_byte (in_last_reg),
        .res       (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (opt.ready)
            in_valid_reg <= opt.valid;
    end

    always_ff @(posedge clk)
    begin
        if (opt.ready && opt.valid)
        begin
            in_byte_reg <= opt.opt_byte;
            in_last_reg <= opt.last_byte;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (step_go && in_last_reg)
            out_valid_reg <= 1'b1;
        else if (res.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (step_go && in_last_reg)
            out_reg <= step_res;
    end

    assign res.valid    = out_valid_reg;
    assign res.status   = out_reg.status;
    assign res.ts_value = out_reg.ts_value;
    assign res.ts_reply = out_reg.ts_reply;

endmodule

@@ rtl/core/tcpts_parse.sv @@
// option walker: parser state registers and the per-byte state update
module tcpts_parse
    import tcpts_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic [7:0] opt_byte,
    input  logic       last_byte,
    output result_t    res
);

    typedef enum logic [2:0] {
        PH_KIND    = 3'd0,
        PH_LEN     = 3'd1,
        PH_SKIP    = 3'd2,
        PH_CAPTURE = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic        is_ts_reg, is_ts_next;
    logic [7:0]  left_reg, left_next;
    logic [63:0] cap_reg, cap_next;
    status_t     final_reg, final_next;

    always_comb
    begin
        phase_next = phase_reg;
        is_ts_next = is_ts_reg;
        left_next  = left_reg;
        cap_next   = cap_reg;
        final_next = final_reg;
        unique case (phase_reg)
            PH_KIND:
            begin
                if (opt_byte == KIND_END)
                begin
                    final_next = ST_EOL;
                    phase_next = PH_DONE;
                end
                else if (opt_byte != KIND_NOP)
                begin
                    is_ts_next = (opt_byte == KIND_TS);
                    phase_next = PH_LEN;
                end
            end
            PH_LEN:
            begin
                if (opt_byte < LEN_MIN)
                begin
                    final_next = ST_BAD;
                    phase_next = PH_DONE;
                end
                else if (is_ts_reg && opt_byte == LEN_TS)
                begin
                    left_next  = TS_BODY_BYTES;
                    cap_next   = '0;
                    phase_next = PH_CAPTURE;
                end
                else
                begin
                    left_next  = opt_byte - LEN_MIN;
                    phase_next = (opt_byte == LEN_MIN) ? PH_KIND : PH_SKIP;
                end
            end
            PH_SKIP:
            begin
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1)
                    phase_next = PH_KIND;
            end
            PH_CAPTURE:
            begin
                cap_next  = {cap_reg[55:0], opt_byte};
                left_next = left_reg - 8'd1;
                if (left_reg == 8'd1)
                begin
                    final_next = ST_FOUND;
                    phase_next = PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
    end

    // status as it stands after this byte
    always_comb
    begin
        res = '0;
        if (phase_next == PH_DONE)
            res.status = final_next;
        else if (phase_next == PH_KIND)
            res.status = ST_NONE;
        else
            res.status = ST_BAD;
        if (res.status == ST_FOUND)
        begin
            res.ts_value = cap_next[63:32];
            res.ts_reply = cap_next[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_KIND;
            is_ts_reg <= 1'b0;
            left_reg  <= '0;
            cap_reg   <= '0;
            final_reg <= ST_NONE;
        end
        else if (en)
        begin
            // the last byte closes the area and rearms for the next one
            if (last_byte)
            begin
                phase_reg <= PH_KIND;
                is_ts_reg <= 1'b0;
                left_reg  <= '0;
                cap_reg   <= '0;
                final_reg <= ST_NONE;
            end
            else
            begin
                phase_reg <= phase_next;
                is_ts_reg <= is_ts_next;
                left_reg  <= left_next;
                cap_reg   <= cap_next;
                final_reg <= final_next;
            end
        end
    end

endmodule
